// ===== rtl/client_server_matcher_assert.svh =====
// assertion macros for the client/server matcher
// expects signals clk and rst in the scope of each use
`ifndef CLIENT_SERVER_MATCHER_ASSERT_SVH
`define CLIENT_SERVER_MATCHER_ASSERT_SVH

// antecedent holds, consequent checked in the same cycle
`define CSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent checked in the following cycle
`define CSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent holds, consequent checked later
`define CSM_ASSERT_LATER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== rtl/csm_pkg.sv =====
// shared constants and types for the client/server matcher
// no dependencies
package csm_pkg;

  // default sizes
  localparam int NUM_CLIENTS        = 16;
  localparam int NUM_SERVERS        = 4;
  localparam int CLIENT_QUEUE_DEPTH = 8;

  // field widths
  localparam int ID_W    = 4;
  localparam int SID_W   = 2;
  localparam int OC_W    = 2;
  localparam int SEATS_W = 4;

  localparam logic [SEATS_W-1:0] RESET_SEATS = 4'd5;

  typedef enum logic {
    FUNC_SERVER = 1'b0,
    FUNC_CLIENT = 1'b1
  } csm_func_t;

  typedef enum logic [OC_W-1:0] {
    OC_REJECT = 2'd0,
    OC_MATCH  = 2'd1,
    OC_DROP   = 2'd2
  } csm_outcome_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } csm_state_t;

endpackage

// ===== rtl/csm_if.sv =====
// valid/ready channel interfaces for arrivals and results
// depends on csm_pkg for field widths
interface csm_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [csm_pkg::ID_W-1:0] requester_id;

  modport source (output valid, output func, output requester_id, input ready);
  modport sink   (input valid, input func, input requester_id, output ready);
endinterface

interface csm_out_if;
  logic                      valid;
  logic                      ready;
  logic [csm_pkg::OC_W-1:0]  outcome;
  logic [csm_pkg::ID_W-1:0]  client_id;
  logic [csm_pkg::SID_W-1:0] server_id;

  modport source (output valid, output outcome, output client_id, output server_id,
                  input ready);
  modport sink   (input valid, input outcome, input client_id, input server_id,
                  output ready);
endinterface

// ===== rtl/client_server_matcher.sv =====
// top level of the client/server matcher: control plus the two queue memories
// depends on csm_pkg, csm_if, csm_ram, csm_ctrl and the assertion header
//
// channel   dir  transfer payload
// arrival   in   func, requester_id
// result    out  outcome, client_id, server_id
// cfg       in   cfg_we/cfg_wdata write of the seat cap
//
// an arrival that queues or gets an immediate result (reject, drop) is handled in ST_IDLE;
// an arrival that matches also passes through ST_READ: the pop reads a queue memory with a
// registered read, and the result is loaded from the read data
// reset clears pointers, counts and the result valid flag, and sets the seat cap to 5
// a result waiting in the output register holds back arrivals only until transferred
`include "client_server_matcher_assert.svh"

module client_server_matcher #(
  parameter int NUM_SERVERS        = csm_pkg::NUM_SERVERS,
  parameter int CLIENT_QUEUE_DEPTH = csm_pkg::CLIENT_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  csm_in_if.sink                      arrival,
  csm_out_if.source                   result,
  input  logic                        cfg_we,
  input  logic [csm_pkg::SEATS_W-1:0] cfg_wdata
);
  import csm_pkg::*;

  localparam int CAW = (CLIENT_QUEUE_DEPTH > 1) ? $clog2(CLIENT_QUEUE_DEPTH) : 1;
  localparam int SAW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic             c_we, c_re, s_we, s_re;
  logic [CAW-1:0]   c_waddr, c_raddr;
  logic [ID_W-1:0]  c_wdata, c_rdata;
  logic [SAW-1:0]   s_waddr, s_raddr;
  logic [SID_W-1:0] s_wdata, s_rdata;

  // control and result register
  csm_ctrl #(
    .NUM_SERVERS        (NUM_SERVERS),
    .CLIENT_QUEUE_DEPTH (CLIENT_QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .arrival   (arrival),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .c_we      (c_we),
    .c_waddr   (c_waddr),
    .c_wdata   (c_wdata),
    .c_re      (c_re),
    .c_raddr   (c_raddr),
    .c_rdata   (c_rdata),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .s_wdata   (s_wdata),
    .s_re      (s_re),
    .s_raddr   (s_raddr),
    .s_rdata   (s_rdata)
  );

  // waiting client ids
  csm_ram #(
    .WIDTH (ID_W),
    .DEPTH (CLIENT_QUEUE_DEPTH)
  ) u_client_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // idle server ids
  csm_ram #(
    .WIDTH (SID_W),
    .DEPTH (NUM_SERVERS)
  ) u_server_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // checks
  `CSM_ASSERT_LATER2(a_pop_gives_result, c_re || s_re, result.valid, "pop without result")
  `CSM_ASSERT_NEXT(a_pop_blocks_arrival, c_re || s_re, !arrival.ready, "arrival during pop")
  `CSM_ASSERT_NOW(a_one_ram_op, c_we || s_we, !c_re && !s_re && !(c_we && s_we), "two ram ops")

endmodule

// ===== rtl/csm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module csm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/csm_ctrl.sv =====
// queue pointers, matching decision, ram requests and result register
// depends on csm_pkg and the channel interfaces
module csm_ctrl #(
  parameter int NUM_SERVERS        = csm_pkg::NUM_SERVERS,
  parameter int CLIENT_QUEUE_DEPTH = csm_pkg::CLIENT_QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  csm_in_if.sink                                arrival,
  csm_out_if.source                             result,
  input  logic                                  cfg_we,
  input  logic [csm_pkg::SEATS_W-1:0]           cfg_wdata,
  // client queue memory
  output logic                                  c_we,
  output logic [(CLIENT_QUEUE_DEPTH > 1 ? $clog2(CLIENT_QUEUE_DEPTH) : 1)-1:0] c_waddr,
  output logic [csm_pkg::ID_W-1:0]              c_wdata,
  output logic                                  c_re,
  output logic [(CLIENT_QUEUE_DEPTH > 1 ? $clog2(CLIENT_QUEUE_DEPTH) : 1)-1:0] c_raddr,
  input  logic [csm_pkg::ID_W-1:0]              c_rdata,
  // server queue memory
  output logic                                  s_we,
  output logic [(NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1)-1:0] s_waddr,
  output logic [csm_pkg::SID_W-1:0]             s_wdata,
  output logic                                  s_re,
  output logic [(NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1)-1:0] s_raddr,
  input  logic [csm_pkg::SID_W-1:0]             s_rdata
);
  import csm_pkg::*;

  localparam int CAW   = (CLIENT_QUEUE_DEPTH > 1) ? $clog2(CLIENT_QUEUE_DEPTH) : 1;
  localparam int CCW   = $clog2(CLIENT_QUEUE_DEPTH + 1);
  localparam int CSW   = CCW + 1;
  localparam int CMP_W = (CCW > SEATS_W) ? CCW : SEATS_W;
  localparam int SAW   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SCW   = $clog2(NUM_SERVERS + 1);
  localparam int SSW   = SCW + 1;
  localparam int NS_W  = 8;
  localparam int NUM_IDS = 1 << ID_W;

  // state registers
  csm_state_t       state, state_next;
  logic [CAW-1:0]   client_head, client_head_next;
  logic [CCW-1:0]   client_count, client_count_next;
  logic [SAW-1:0]   server_head, server_head_next;
  logic [SCW-1:0]   server_count, server_count_next;
  logic [SEATS_W-1:0] seat_cap;

  // pending match waiting on ram data
  logic             pend_srv_ram, pend_srv_ram_next;
  logic [ID_W-1:0]  pend_cid, pend_cid_next;
  logic [SID_W-1:0] pend_sid, pend_sid_next;

  // result register
  logic             out_valid, out_valid_next;
  csm_outcome_t     res_outcome, res_outcome_next;
  logic [ID_W-1:0]  res_cid, res_cid_next;
  logic [SID_W-1:0] res_sid, res_sid_next;

  logic             acc;
  logic [ID_W-1:0]  cid;
  logic [SID_W-1:0] sid;
  logic             sid_ok;
  logic             reject;
  logic [CSW-1:0]   c_slot_sum;
  logic [CSW-1:0]   c_slot;
  logic [SSW-1:0]   s_slot_sum;
  logic [SSW-1:0]   s_slot;
  logic [ID_W-1:0]  cid_map [NUM_IDS];

  // client id reduction table, built at elaboration
  for (genvar i = 0; i < NUM_IDS; i++) begin : g_cid_map
    localparam int RED = i % NUM_CLIENTS;
    assign cid_map[i] = ID_W'(RED);
  end

  assign acc = arrival.valid && arrival.ready;
  assign cid = cid_map[arrival.requester_id];
  assign sid = arrival.requester_id[SID_W-1:0];
  assign sid_ok = NS_W'(arrival.requester_id) < NS_W'(NUM_SERVERS);

  // seat limit is the smaller of the register and the storage depth
  assign reject = (CMP_W'(client_count) >= CMP_W'(seat_cap)) ||
                  (client_count == CCW'(CLIENT_QUEUE_DEPTH));

  // tail slots, wrapped without a divider
  assign c_slot_sum = CSW'(client_head) + CSW'(client_count);
  assign c_slot = (c_slot_sum >= CSW'(CLIENT_QUEUE_DEPTH)) ?
                  c_slot_sum - CSW'(CLIENT_QUEUE_DEPTH) : c_slot_sum;
  assign s_slot_sum = SSW'(server_head) + SSW'(server_count);
  assign s_slot = (s_slot_sum >= SSW'(NUM_SERVERS)) ?
                  s_slot_sum - SSW'(NUM_SERVERS) : s_slot_sum;

  // new arrival only from idle with the result register free or draining
  assign arrival.ready = (state == ST_IDLE) && (!out_valid || result.ready);

  assign result.valid     = out_valid;
  assign result.outcome   = res_outcome;
  assign result.client_id = res_cid;
  assign result.server_id = res_sid;

  // ram request addresses
  assign c_waddr = c_slot[CAW-1:0];
  assign c_wdata = cid;
  assign c_raddr = client_head;
  assign s_waddr = s_slot[SAW-1:0];
  assign s_wdata = sid;
  assign s_raddr = server_head;

  // state register, queue pointers, result valid flag and seat cap
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      client_head  <= '0;
      client_count <= '0;
      server_head  <= '0;
      server_count <= '0;
      out_valid    <= 1'b0;
      seat_cap     <= RESET_SEATS;
    end else begin
      state        <= state_next;
      client_head  <= client_head_next;
      client_count <= client_count_next;
      server_head  <= server_head_next;
      server_count <= server_count_next;
      out_valid    <= out_valid_next;
      if (cfg_we) begin
        seat_cap <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_srv_ram <= pend_srv_ram_next;
    pend_cid     <= pend_cid_next;
    pend_sid     <= pend_sid_next;
    res_outcome  <= res_outcome_next;
    res_cid      <= res_cid_next;
    res_sid      <= res_sid_next;
  end

  // matching decision
  always_comb begin
    state_next        = state;
    client_head_next  = client_head;
    client_count_next = client_count;
    server_head_next  = server_head;
    server_count_next = server_count;
    pend_srv_ram_next = pend_srv_ram;
    pend_cid_next     = pend_cid;
    pend_sid_next     = pend_sid;
    res_outcome_next  = res_outcome;
    res_cid_next      = res_cid;
    res_sid_next      = res_sid;
    out_valid_next    = out_valid && !result.ready;
    c_we = 1'b0;
    c_re = 1'b0;
    s_we = 1'b0;
    s_re = 1'b0;

    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (arrival.func == FUNC_CLIENT) begin
            if (reject) begin
              out_valid_next   = 1'b1;
              res_outcome_next = OC_REJECT;
              res_cid_next     = cid;
              res_sid_next     = '0;
            end else if (client_count == '0 && server_count != '0) begin
              // pop oldest idle server
              s_re              = 1'b1;
              server_head_next  = (server_head == SAW'(NUM_SERVERS - 1)) ?
                                  '0 : server_head + SAW'(1);
              server_count_next = server_count - SCW'(1);
              pend_srv_ram_next = 1'b1;
              pend_cid_next     = cid;
              state_next        = ST_READ;
            end else begin
              c_we              = 1'b1;
              client_count_next = client_count + CCW'(1);
            end
          end else if (sid_ok) begin
            if (client_count != '0) begin
              // pop oldest waiting client
              c_re              = 1'b1;
              client_head_next  = (client_head == CAW'(CLIENT_QUEUE_DEPTH - 1)) ?
                                  '0 : client_head + CAW'(1);
              client_count_next = client_count - CCW'(1);
              pend_srv_ram_next = 1'b0;
              pend_sid_next     = sid;
              state_next        = ST_READ;
            end else if (server_count == SCW'(NUM_SERVERS)) begin
              out_valid_next   = 1'b1;
              res_outcome_next = OC_DROP;
              res_cid_next     = '0;
              res_sid_next     = sid;
            end else begin
              s_we              = 1'b1;
              server_count_next = server_count + SCW'(1);
            end
          end
        end
      end
      ST_READ: begin
        // ram data arrives, result register is free here
        out_valid_next   = 1'b1;
        res_outcome_next = OC_MATCH;
        res_cid_next     = pend_srv_ram ? pend_cid : c_rdata;
        res_sid_next     = pend_srv_ram ? s_rdata : pend_sid;
        state_next       = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
